>>> rtl/sha256_hash_engine_core_macros.svh
// Assertion macros for the SHA-256 hash engine.
// Used by rtl/sha256_hash_engine_core.sv; no other dependencies.
`ifndef SHA256_HASH_ENGINE_CORE_MACROS_SVH
`define SHA256_HASH_ENGINE_CORE_MACROS_SVH
`ifndef SYNTH
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SHA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SHA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/sha_pkg.sv
// Package for the SHA-256 hash engine: round constants, initial hash, FSM type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sha_pkg;
    localparam int unsigned BlockBytes = 64;
    localparam int unsigned Rounds     = 64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_OUT
    } t_state;

    function automatic logic [31:0] f_k(input logic [5:0] i);
        logic [31:0] k;
        begin
            unique case (i)
                6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
                6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
                6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
                6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
                6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
                6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
                6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
                6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
                6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
                6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
                6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
                6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
                6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
                6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
                6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
                6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
                6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
                6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
                6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
                6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
                6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
                6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
                6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
                6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
                6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
                6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
                6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
                6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
                6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
                6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
                6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
                6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
                default: k = 32'h0;
            endcase
            return k;
        end
    endfunction

    function automatic logic [31:0] f_h0(input logic [2:0] i);
        logic [31:0] h;
        begin
            unique case (i)
                3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
                3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
                3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
                3'd6: h = 32'h1f83d9ab; 3'd7: h = 32'h5be0cd19;
                default: h = 32'h0;
            endcase
            return h;
        end
    endfunction

    function automatic logic [31:0] f_rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction
endpackage
`default_nettype wire

>>> rtl/sha_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module sha_ram #(
    parameter int unsigned Width = 8,
    parameter int unsigned Depth = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> rtl/sha256_hash_engine_core.sv
// SHA-256 engine top level: byte gathering, padding, 64-round compression.
// Depends on sha_pkg, sha_ram and sha256_hash_engine_core_macros.svh.
// Bytes stream in one per cycle into a 64-byte block memory. When a block fills, or on the
// end mark, the engine stops accepting requests and compresses the block: the padding pass
// writes one byte per cycle up to the end of the block, then 16 message words are read from
// the block memory, one byte per cycle, the 64 rounds run at one per cycle, each consuming
// a schedule word kept in a 16-word window, and the eight hash words are folded back. A full
// block costs 64 accepted bytes plus the load, round and fold passes; the end mark adds the
// pad pass and up to one extra block before the eight digest words leave, one request each.
`timescale 1ns / 1ps
`default_nettype none
`include "sha256_hash_engine_core_macros.svh"
module sha256_hash_engine_core
    import sha_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // [7:0] data_byte
    input  wire logic        s_axis_tuser,  // has_byte
    input  wire logic        s_axis_tlast,  // is_last
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,  // [31:0] digest_word, [34:32] word_index, pad
    output logic             m_axis_tlast   // last_word
);
    t_state r_state, n_state;

    logic [5:0]  r_fill;
    logic [63:0] r_bits;
    logic        r_final;       // finishing the message
    logic        r_two;         // length goes in a second block
    logic        r_lenblk;      // current pad block carries the length
    logic [6:0]  r_cnt;         // pad / load / round counter
    logic [31:0] r_hash [8];
    logic [31:0] r_v [8];
    logic [31:0] r_w [16];
    logic [2:0]  r_oidx;

    // block memory signals
    logic        mem_we;
    logic [5:0]  mem_waddr, mem_raddr;
    logic [7:0]  mem_wdata, mem_rdata;
    logic        r_rd_vld;
    logic [5:0]  r_rd_addr;

    sha_ram #(.Width(8), .Depth(BlockBytes)) u_block_ram (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    logic acc_in;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign acc_in = s_axis_tvalid && s_axis_tready;

    // padding byte for the current pad position
    logic [7:0] pad_byte;
    logic [5:0] pad_pos;
    assign pad_pos = r_cnt[5:0];
    always_comb begin
        pad_byte = 8'h00;
        if (r_lenblk && pad_pos >= 6'd56) begin
            pad_byte = r_bits[8'(7 - (pad_pos - 6'd56)) * 8 +: 8];
        end
        if (!r_lenblk && pad_pos == r_fill) begin
            pad_byte = 8'h80;
        end
        if (r_lenblk && !r_two && pad_pos == r_fill) begin
            pad_byte = 8'h80;
        end
    end

    // memory port steering
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_fill;
        mem_wdata = s_axis_tdata;
        mem_raddr = r_cnt[5:0];
        if (acc_in && s_axis_tuser) begin
            mem_we = 1'b1;
        end
        if (r_state == ST_PAD) begin
            mem_we    = 1'b1;
            mem_waddr = pad_pos;
            mem_wdata = pad_byte;
        end
    end

    // round logic
    logic [31:0] s1, ch, t1, s0, mj, wt, ws0, ws1, wnew;
    always_comb begin
        wt  = r_w[0];
        s1  = f_rotr(r_v[4], 6) ^ f_rotr(r_v[4], 11) ^ f_rotr(r_v[4], 25);
        ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        t1  = r_v[7] + s1 + ch + f_k(r_cnt[5:0]) + wt;
        s0  = f_rotr(r_v[0], 2) ^ f_rotr(r_v[0], 13) ^ f_rotr(r_v[0], 22);
        mj  = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        ws0 = f_rotr(r_w[1], 7) ^ f_rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        ws1 = f_rotr(r_w[14], 17) ^ f_rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        wnew = ws1 + r_w[9] + ws0 + r_w[0];
    end

    logic done_in;
    assign done_in = (r_state == ST_OUT) && m_axis_tready && (r_oidx == 3'd7);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (acc_in && s_axis_tuser && r_fill == 6'd63) begin
                    n_state = ST_LOAD;
                end else if (acc_in && s_axis_tlast) begin
                    n_state = ST_PAD;
                end
            end
            ST_PAD:   if (r_cnt == 7'd63) n_state = ST_LOAD;
            ST_LOAD:  if (r_cnt == 7'd64) n_state = ST_ROUND;
            ST_ROUND: if (r_cnt == 7'd63) n_state = ST_FOLD;
            ST_FOLD: begin
                if (r_final && r_lenblk) begin
                    n_state = ST_OUT;
                end else if (r_final) begin
                    n_state = ST_PAD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_OUT:   if (done_in) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= '0;
            r_bits   <= '0;
            r_final  <= 1'b0;
            r_two    <= 1'b0;
            r_lenblk <= 1'b0;
            r_cnt    <= '0;
            r_oidx   <= '0;
            r_rd_vld <= 1'b0;
            for (int i = 0; i < 8; i++) r_hash[i] <= f_h0(3'(i));
        end else begin
            r_rd_vld  <= (r_state == ST_LOAD) && (r_cnt < 7'd64);
            r_rd_addr <= r_cnt[5:0];
            unique case (r_state)
                ST_IDLE: begin
                    r_cnt <= '0;
                    if (acc_in) begin
                        logic [5:0] f;
                        logic [63:0] b;
                        f = r_fill;
                        b = r_bits;
                        if (s_axis_tuser) begin
                            f = r_fill + 6'd1;
                            b = r_bits + 64'd8;
                        end
                        r_fill <= f;
                        r_bits <= b;
                        if (s_axis_tlast) begin
                            r_final  <= 1'b1;
                            r_two    <= (f >= 6'd56);
                            r_lenblk <= (f < 6'd56);
                            if (s_axis_tuser && f == 6'd0) begin
                                r_two    <= 1'b0;
                                r_lenblk <= 1'b0;
                            end
                        end
                        // a full block with end mark: pad block follows that carries length
                        if (s_axis_tuser && r_fill == 6'd63) begin
                            r_cnt <= '0;
                        end else if (s_axis_tlast) begin
                            r_cnt <= {1'b0, f};
                        end
                    end
                end
                ST_PAD:  r_cnt <= (r_cnt == 7'd63) ? 7'd0 : r_cnt + 7'd1;
                ST_LOAD: begin
                    r_cnt <= (r_cnt == 7'd64) ? 7'd0 : r_cnt + 7'd1;
                    if (r_cnt == 7'd0) begin
                        for (int i = 0; i < 8; i++) r_v[i] <= r_hash[i];
                    end
                    if (r_rd_vld) begin
                        // a new word starts: push the finished one down the window
                        if (r_rd_addr[1:0] == 2'd0) begin
                            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i + 1];
                        end
                        r_w[15] <= {r_w[15][23:0], mem_rdata};
                    end
                end
                ST_ROUND: begin
                    r_cnt <= (r_cnt == 7'd63) ? 7'd0 : r_cnt + 7'd1;
                    for (int i = 0; i < 15; i++) r_w[i] <= r_w[i + 1];
                    r_w[15] <= wnew;
                    r_v[7] <= r_v[6];
                    r_v[6] <= r_v[5];
                    r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2];
                    r_v[2] <= r_v[1];
                    r_v[1] <= r_v[0];
                    r_v[0] <= t1 + s0 + mj;
                end
                ST_FOLD: begin
                    for (int i = 0; i < 8; i++) r_hash[i] <= r_hash[i] + r_v[i];
                    r_cnt <= '0;
                    if (r_final && !r_lenblk) begin
                        // next pad block carries the length; 0x80 only if not yet placed
                        r_lenblk <= 1'b1;
                    end
                end
                ST_OUT: begin
                    if (m_axis_tready) begin
                        r_oidx <= r_oidx + 3'd1;
                        if (r_oidx == 3'd7) begin
                            for (int i = 0; i < 8; i++) r_hash[i] <= f_h0(3'(i));
                            r_fill   <= '0;
                            r_bits   <= '0;
                            r_final  <= 1'b0;
                            r_two    <= 1'b0;
                            r_lenblk <= 1'b0;
                        end
                    end
                end
                default: r_cnt <= '0;
            endcase
        end
    end

    // output channel
    assign m_axis_tvalid = (r_state == ST_OUT);
    assign m_axis_tdata  = {5'd0, r_oidx, r_hash[r_oidx]};
    assign m_axis_tlast  = (r_oidx == 3'd7);

    `SHA_ASSERT_IMP(a_no_in_busy, i_clk, i_rst_n, r_state != ST_IDLE, !s_axis_tready)
    `SHA_ASSERT_IMP(a_out_only_final, i_clk, i_rst_n, m_axis_tvalid, r_final && r_lenblk)
    `SHA_ASSERT_NXT(a_done_idle, i_clk, i_rst_n, done_in, r_state == ST_IDLE && r_bits == 64'd0)
endmodule
`default_nettype wire
